FILE: hw/rtl/dstp_pkg.sv
package dstp_pkg;

  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned PROD_W  = 58;
  localparam int unsigned ACC_W   = 61;
  localparam int unsigned TURN_W  = 25;
  localparam int unsigned SPEED_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_LAT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_LAT  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_LAT  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P_HEAD = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D_HEAD = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I_HEAD = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_DIST   = 4'd7;

  localparam logic [GAIN_W-1:0] RST_GAIN_P_LAT  = 24'd1966080;
  localparam logic [GAIN_W-1:0] RST_GAIN_D_LAT  = 24'd327680;
  localparam logic [GAIN_W-1:0] RST_GAIN_I_LAT  = 24'd1966;
  localparam logic [GAIN_W-1:0] RST_GAIN_P_HEAD = 24'd327680;
  localparam logic [GAIN_W-1:0] RST_GAIN_D_HEAD = 24'd0;
  localparam logic [GAIN_W-1:0] RST_GAIN_I_HEAD = 24'd0;
  localparam logic [GAIN_W-1:0] RST_TURN_LIMIT  = 24'd26214;
  localparam logic [GAIN_W-1:0] RST_STOP_DIST   = 24'd197;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p_lat;
    logic [GAIN_W-1:0] gain_d_lat;
    logic [GAIN_W-1:0] gain_i_lat;
    logic [GAIN_W-1:0] gain_p_head;
    logic [GAIN_W-1:0] gain_d_head;
    logic [GAIN_W-1:0] gain_i_head;
    logic [GAIN_W-1:0] turn_limit;
    logic [GAIN_W-1:0] stop_dist;
  } dstp_cfg_t;

  typedef struct packed {
    logic ok;
    logic stop;
    logic near;
  } dstp_flags_t;

  typedef struct packed {
    logic signed [31:0] e_lat;
    logic signed [32:0] d_lat;
    logic signed [31:0] sum_lat;
    logic signed [19:0] e_head;
    logic signed [20:0] d_head;
    logic signed [31:0] sum_head;
    dstp_flags_t        flags;
  } dstp_ops_t;

endpackage

FILE: hw/rtl/dstp_cfg.sv
module dstp_cfg
  import dstp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAIN_W-1:0]    cfg_data_i,
  output dstp_cfg_t            cfg_o
);

  dstp_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_GAIN_P_LAT:  cfg_d.gain_p_lat  = cfg_data_i;
        REG_GAIN_D_LAT:  cfg_d.gain_d_lat  = cfg_data_i;
        REG_GAIN_I_LAT:  cfg_d.gain_i_lat  = cfg_data_i;
        REG_GAIN_P_HEAD: cfg_d.gain_p_head = cfg_data_i;
        REG_GAIN_D_HEAD: cfg_d.gain_d_head = cfg_data_i;
        REG_GAIN_I_HEAD: cfg_d.gain_i_head = cfg_data_i;
        REG_TURN_LIMIT:  cfg_d.turn_limit  = cfg_data_i;
        REG_STOP_DIST:   cfg_d.stop_dist   = cfg_data_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p_lat  <= RST_GAIN_P_LAT;
      cfg_q.gain_d_lat  <= RST_GAIN_D_LAT;
      cfg_q.gain_i_lat  <= RST_GAIN_I_LAT;
      cfg_q.gain_p_head <= RST_GAIN_P_HEAD;
      cfg_q.gain_d_head <= RST_GAIN_D_HEAD;
      cfg_q.gain_i_head <= RST_GAIN_I_HEAD;
      cfg_q.turn_limit  <= RST_TURN_LIMIT;
      cfg_q.stop_dist   <= RST_STOP_DIST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: hw/rtl/dstp_err.sv
module dstp_err
  import dstp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic               first_tick_i,
  input  logic               data_ok_i,
  input  logic signed [31:0] pos_forward_i,
  input  logic signed [31:0] pos_lateral_i,
  input  logic signed [18:0] pos_heading_i,
  input  logic [GAIN_W-1:0]  stop_dist_i,
  output logic               valid_o,
  input  logic               ready_i,
  output dstp_ops_t          ops_o
);

  localparam longint unsigned OneQ = 64'd1 << FRAC_BITS;
  localparam logic signed [32:0] K_0_01 = 33'((OneQ + 64'd50) / 64'd100);
  localparam logic signed [32:0] K_0_5  = 33'(OneQ >> 1);
  localparam logic signed [32:0] K_0_1  = 33'((OneQ + 64'd5) / 64'd10);

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat33 = {v[32], {31{~v[32]}}};
    end else begin
      sat33 = v[31:0];
    end
  endfunction

  logic signed [31:0] prev_lat_q, prev_lat_d, sum_lat_q, sum_lat_d;
  logic signed [19:0] prev_head_q, prev_head_d;
  logic signed [31:0] sum_head_q, sum_head_d;
  logic               vld_q;
  dstp_ops_t          ops_q, ops_d;

  logic               accept;
  logic signed [31:0] pl, sl, sh;
  logic signed [19:0] ph, e_head;
  logic signed [32:0] x_ext, y_ext, ay;
  logic signed [32:0] d_lat;
  logic signed [20:0] d_head;
  logic signed [31:0] new_sl, new_sh;
  logic               integ;

  assign ready_o = !vld_q || ready_i;
  assign accept  = valid_i && ready_o;
  assign valid_o = vld_q;
  assign ops_o   = ops_q;

  always_comb begin
    pl = first_tick_i ? 32'sd0 : prev_lat_q;
    sl = first_tick_i ? 32'sd0 : sum_lat_q;
    ph = first_tick_i ? 20'sd0 : prev_head_q;
    sh = first_tick_i ? 32'sd0 : sum_head_q;

    e_head = -$signed({pos_heading_i[18], pos_heading_i});
    x_ext  = {pos_forward_i[31], pos_forward_i};
    y_ext  = {pos_lateral_i[31], pos_lateral_i};
    ay     = y_ext[32] ? -y_ext : y_ext;
    integ  = (ay < K_0_01) && (x_ext < K_0_5);

    d_lat  = y_ext - {pl[31], pl};
    d_head = {e_head[19], e_head} - {ph[19], ph};
    new_sl = integ ? sat33({sl[31], sl} + y_ext) : sl;
    new_sh = integ ? sat33({sh[31], sh} + {{13{e_head[19]}}, e_head}) : sh;

    prev_lat_d  = prev_lat_q;
    prev_head_d = prev_head_q;
    sum_lat_d   = sum_lat_q;
    sum_head_d  = sum_head_q;
    if (accept) begin
      if (data_ok_i) begin
        prev_lat_d  = pos_lateral_i;
        prev_head_d = e_head;
        sum_lat_d   = new_sl;
        sum_head_d  = new_sh;
      end else if (first_tick_i) begin
        prev_lat_d  = '0;
        prev_head_d = '0;
        sum_lat_d   = '0;
        sum_head_d  = '0;
      end
    end

    ops_d.e_lat      = pos_lateral_i;
    ops_d.d_lat      = d_lat;
    ops_d.sum_lat    = new_sl;
    ops_d.e_head     = e_head;
    ops_d.d_head     = integ ? d_head : 21'sd0;
    ops_d.sum_head   = integ ? new_sh : 32'sd0;
    ops_d.flags.ok   = data_ok_i;
    ops_d.flags.stop = x_ext < $signed({9'b0, stop_dist_i});
    ops_d.flags.near = x_ext < K_0_1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_lat_q  <= '0;
      prev_head_q <= '0;
      sum_lat_q   <= '0;
      sum_head_q  <= '0;
      vld_q       <= 1'b0;
    end else begin
      prev_lat_q  <= prev_lat_d;
      prev_head_q <= prev_head_d;
      sum_lat_q   <= sum_lat_d;
      sum_head_q  <= sum_head_d;
      if (ready_o) begin
        vld_q <= valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ops_q <= ops_d;
    end
  end

endmodule

FILE: hw/rtl/dstp_mac.sv
module dstp_mac
  import dstp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  dstp_ops_t               ops_i,
  input  dstp_cfg_t               cfg_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic signed [ACC_W-1:0] acc_o,
  output dstp_flags_t             flags_o
);

  logic signed [PROD_W-1:0] prod_q [6];
  logic signed [PROD_W-1:0] prod_d [6];
  logic signed [32:0]       opnd [6];
  logic [GAIN_W-1:0]        gain [6];
  dstp_flags_t              flags_b_q, flags_c_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     vb_q, vc_q, ready_b, ready_c;

  assign ready_c = !vc_q || ready_i;
  assign ready_b = !vb_q || ready_c;
  assign ready_o = ready_b;
  assign valid_o = vc_q;
  assign acc_o   = acc_q;
  assign flags_o = flags_c_q;

  always_comb begin
    gain[0] = cfg_i.gain_p_lat;
    gain[1] = cfg_i.gain_d_lat;
    gain[2] = cfg_i.gain_i_lat;
    gain[3] = cfg_i.gain_p_head;
    gain[4] = cfg_i.gain_d_head;
    gain[5] = cfg_i.gain_i_head;
    opnd[0] = {ops_i.e_lat[31], ops_i.e_lat};
    opnd[1] = ops_i.d_lat;
    opnd[2] = {ops_i.sum_lat[31], ops_i.sum_lat};
    opnd[3] = {{13{ops_i.e_head[19]}}, ops_i.e_head};
    opnd[4] = {{12{ops_i.d_head[20]}}, ops_i.d_head};
    opnd[5] = {ops_i.sum_head[31], ops_i.sum_head};
    for (int i = 0; i < 6; i++) begin
      prod_d[i] = $signed({1'b0, gain[i]}) * opnd[i];
    end
  end

  always_comb begin
    acc_d = '0;
    for (int i = 0; i < 6; i++) begin
      acc_d = acc_d + {{(ACC_W-PROD_W){prod_q[i][PROD_W-1]}}, prod_q[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (ready_b) begin
        vb_q <= valid_i;
      end
      if (ready_c) begin
        vc_q <= vb_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_b && valid_i) begin
      prod_q    <= prod_d;
      flags_b_q <= ops_i.flags;
    end
    if (ready_c && vb_q) begin
      acc_q     <= acc_d;
      flags_c_q <= flags_b_q;
    end
  end

endmodule

FILE: hw/rtl/dstp_out.sv
module dstp_out
  import dstp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  logic signed [ACC_W-1:0] acc_i,
  input  dstp_flags_t             flags_i,
  input  logic [GAIN_W-1:0]       turn_limit_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output logic [TURN_W-1:0]       turn_rate_o,
  output logic [SPEED_W-1:0]      drive_speed_o,
  output logic                    finished_o,
  output logic                    aborted_o
);

  localparam longint unsigned OneQ = 64'd1 << FRAC_BITS;
  localparam logic [SPEED_W-1:0] SPD_FAR  = SPEED_W'(-((OneQ + 64'd5) / 64'd10));
  localparam logic [SPEED_W-1:0] SPD_NEAR = SPEED_W'(-((OneQ + 64'd10) / 64'd20));

  logic signed [ACC_W-1:0] w, lim, wc;
  logic [TURN_W-1:0]       turn_q, turn_d;
  logic [SPEED_W-1:0]      speed_q, speed_d;
  logic                    fin_q, fin_d, abt_q, abt_d, vld_q;

  assign ready_o       = !vld_q || ready_i;
  assign valid_o       = vld_q;
  assign turn_rate_o   = turn_q;
  assign drive_speed_o = speed_q;
  assign finished_o    = fin_q;
  assign aborted_o     = abt_q;

  always_comb begin
    w   = acc_i >>> FRAC_BITS;
    lim = $signed({{(ACC_W-GAIN_W){1'b0}}, turn_limit_i});
    if (w > lim) begin
      wc = lim;
    end else if (w < -lim) begin
      wc = -lim;
    end else begin
      wc = w;
    end
    if (!flags_i.ok) begin
      turn_d  = '0;
      speed_d = '0;
      fin_d   = 1'b0;
      abt_d   = 1'b1;
    end else if (flags_i.stop) begin
      turn_d  = '0;
      speed_d = '0;
      fin_d   = 1'b1;
      abt_d   = 1'b0;
    end else begin
      turn_d  = wc[TURN_W-1:0];
      speed_d = flags_i.near ? SPD_NEAR : SPD_FAR;
      fin_d   = 1'b0;
      abt_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      turn_q  <= turn_d;
      speed_q <= speed_d;
      fin_q   <= fin_d;
      abt_q   <= abt_d;
    end
  end

endmodule

FILE: hw/rtl/docking_steer_pid.sv
// Pipeline: an input word passes through the error, multiply, sum and clamp
// registers in that order before its result word is valid on the output.
// Throughput: one word per cycle unless the output stalls; error stage, multiply stage,
// sum stage and clamp stage each hold one word behind their own handshake.
// Reset (rst_ni low, asynchronous): gains and limits return to defaults, the
// stored errors and sums clear and the pipeline empties.
module docking_steer_pid
  import dstp_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [87:0]          s_axis_tdata_i,  // pos_forward, pos_lateral, pos_heading
  input  logic [1:0]           s_axis_tuser_i,  // first_tick, data_ok
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [39:0]          m_axis_tdata_o,  // turn_rate, drive_speed
  output logic                 m_axis_tlast_o,  // finished
  output logic [0:0]           m_axis_tuser_o,  // aborted
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [GAIN_W-1:0]    cfg_data_i
);

  dstp_cfg_t               cfg;
  dstp_ops_t               ops;
  dstp_flags_t             flags;
  logic signed [ACC_W-1:0] acc;
  logic                    ops_valid, ops_ready, acc_valid, acc_ready;
  logic [TURN_W-1:0]       turn_rate;
  logic [SPEED_W-1:0]      drive_speed;

  dstp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dstp_err #(
    .FRAC_BITS (FRAC_BITS)
  ) u_err (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid_i),
    .ready_o       (s_axis_tready_o),
    .first_tick_i  (s_axis_tuser_i[0]),
    .data_ok_i     (s_axis_tuser_i[1]),
    .pos_forward_i ($signed(s_axis_tdata_i[31:0])),
    .pos_lateral_i ($signed(s_axis_tdata_i[63:32])),
    .pos_heading_i ($signed(s_axis_tdata_i[82:64])),
    .stop_dist_i   (cfg.stop_dist),
    .valid_o       (ops_valid),
    .ready_i       (ops_ready),
    .ops_o         (ops)
  );

  dstp_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ops_valid),
    .ready_o (ops_ready),
    .ops_i   (ops),
    .cfg_i   (cfg),
    .valid_o (acc_valid),
    .ready_i (acc_ready),
    .acc_o   (acc),
    .flags_o (flags)
  );

  dstp_out #(
    .FRAC_BITS (FRAC_BITS)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (acc_valid),
    .ready_o       (acc_ready),
    .acc_i         (acc),
    .flags_i       (flags),
    .turn_limit_i  (cfg.turn_limit),
    .valid_o       (m_axis_tvalid_o),
    .ready_i       (m_axis_tready_i),
    .turn_rate_o   (turn_rate),
    .drive_speed_o (drive_speed),
    .finished_o    (m_axis_tlast_o),
    .aborted_o     (m_axis_tuser_o[0])
  );

  assign m_axis_tdata_o = {1'b0, drive_speed, turn_rate};

endmodule

FILE: test/tb_docking_steer_pid.sv
`timescale 1ns / 1ps

module tb_docking_steer_pid;
  import dstp_pkg::*;

  localparam int     FRAC_BITS = 16;
  localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
  localparam longint LAT_NEAR  = (ONE_Q + 50) / 100;
  localparam longint FWD_NEAR  = ONE_Q >> 1;
  localparam longint FWD_SLOW  = (ONE_Q + 5) / 10;
  localparam longint SPD_FAST  = (ONE_Q + 5) / 10;
  localparam longint SPD_SLOW  = (ONE_Q + 10) / 20;
  localparam int     NUM_REGS  = 8;

  typedef struct {
    bit                 first;
    bit                 ok;
    logic signed [31:0] fwd;
    logic signed [31:0] lat;
    logic signed [18:0] head;
  } pose_t;

  typedef struct {
    logic signed [TURN_W-1:0]  turn;
    logic signed [SPEED_W-1:0] speed;
    logic                      fin;
    logic                      abt;
  } steer_cmd_t;

  class steer_cmd_board;
    logic [GAIN_W-1:0] gains [NUM_REGS];
    int                prev_lat, sum_lat, prev_head, sum_head;
    steer_cmd_t        pending_cmds [$];
    int                errors;

    function new();
      gains[REG_GAIN_P_LAT]  = RST_GAIN_P_LAT;
      gains[REG_GAIN_D_LAT]  = RST_GAIN_D_LAT;
      gains[REG_GAIN_I_LAT]  = RST_GAIN_I_LAT;
      gains[REG_GAIN_P_HEAD] = RST_GAIN_P_HEAD;
      gains[REG_GAIN_D_HEAD] = RST_GAIN_D_HEAD;
      gains[REG_GAIN_I_HEAD] = RST_GAIN_I_HEAD;
      gains[REG_TURN_LIMIT]  = RST_TURN_LIMIT;
      gains[REG_STOP_DIST]   = RST_STOP_DIST;
      prev_lat  = 0;
      sum_lat   = 0;
      prev_head = 0;
      sum_head  = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      if (idx <= REG_STOP_DIST) begin
        gains[idx] = val;
      end
    endfunction

    function int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function void note_pose(pose_t p);
      longint     g [NUM_REGS];
      longint     x, y, eh, dl, dh, ay, acc, w, lim, spd;
      bit         near;
      steer_cmd_t c;
      foreach (g[i]) g[i] = longint'(gains[i]);
      if (p.first) begin
        prev_lat  = 0;
        sum_lat   = 0;
        prev_head = 0;
        sum_head  = 0;
      end
      c.turn  = '0;
      c.speed = '0;
      c.fin   = 1'b0;
      c.abt   = 1'b0;
      if (!p.ok) begin
        c.abt = 1'b1;
        pending_cmds.push_back(c);
        return;
      end
      x  = p.fwd;
      y  = p.lat;
      eh = p.head;
      eh = -eh;
      dl = y - longint'(prev_lat);
      dh = eh - longint'(prev_head);
      ay = (y < 0) ? -y : y;
      near = (ay < LAT_NEAR) && (x < FWD_NEAR);
      if (near) begin
        sum_lat  = sat32(longint'(sum_lat) + y);
        sum_head = sat32(longint'(sum_head) + eh);
      end
      acc = g[REG_GAIN_P_LAT] * y + g[REG_GAIN_D_LAT] * dl
          + g[REG_GAIN_I_LAT] * longint'(sum_lat) + g[REG_GAIN_P_HEAD] * eh;
      if (near) begin
        acc += g[REG_GAIN_D_HEAD] * dh + g[REG_GAIN_I_HEAD] * longint'(sum_head);
      end
      prev_lat  = int'(y);
      prev_head = int'(eh);
      w   = acc >>> FRAC_BITS;
      lim = g[REG_TURN_LIMIT];
      if (w > lim) w = lim;
      else if (w < -lim) w = -lim;
      if (x < g[REG_STOP_DIST]) begin
        c.fin = 1'b1;
      end else begin
        spd     = (x < FWD_SLOW) ? -SPD_SLOW : -SPD_FAST;
        c.turn  = w[TURN_W-1:0];
        c.speed = spd[SPEED_W-1:0];
      end
      pending_cmds.push_back(c);
    endfunction

    function void check_cmd(logic [39:0] data, logic fin, logic abt);
      steer_cmd_t want;
      logic signed [TURN_W-1:0]  got_turn;
      logic signed [SPEED_W-1:0] got_speed;
      if (pending_cmds.size() == 0) begin
        $display("%0t: result word with none expected, tdata %h", $time, data);
        errors++;
        return;
      end
      want      = pending_cmds.pop_front();
      got_turn  = data[TURN_W-1:0];
      got_speed = data[TURN_W+SPEED_W-1:TURN_W];
      if (got_turn !== want.turn) begin
        $display("%0t: turn_rate expected %0d actual %0d", $time, want.turn, got_turn);
        errors++;
      end
      if (got_speed !== want.speed) begin
        $display("%0t: drive_speed expected %0d actual %0d", $time, want.speed, got_speed);
        errors++;
      end
      if (fin !== want.fin) begin
        $display("%0t: finished expected %b actual %b", $time, want.fin, fin);
        errors++;
      end
      if (abt !== want.abt) begin
        $display("%0t: aborted expected %b actual %b", $time, want.abt, abt);
        errors++;
      end
    endfunction
  endclass

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 s_tvalid  = 1'b0;
  logic [87:0]          s_tdata   = '0;
  logic [1:0]           s_tuser   = '0;
  logic                 m_tready  = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]    cfg_data  = '0;

  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [39:0]          m_axis_tdata_o;
  logic                 m_axis_tlast_o;
  logic [0:0]           m_axis_tuser_o;
  logic                 cfg_ready_o;

  steer_cmd_board       board = new();
  pose_t                stim_q [$];
  logic [GAIN_W-1:0]    cfg_set [NUM_REGS];

  docking_steer_pid #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void add_pose(int first, int ok, int fwd, int lat, int head);
    pose_t p;
    p.first = first[0];
    p.ok    = ok[0];
    p.fwd   = fwd;
    p.lat   = lat;
    p.head  = head[18:0];
    stim_q.push_back(p);
  endfunction

  // approach run: forward distance closing, lateral and heading settling
  function automatic void add_run();
    int len, fwd, lat, head;
    len  = $urandom_range(3, 20);
    fwd  = $urandom_range(1000, 45000);
    lat  = int'($urandom_range(4000)) - 2000;
    head = int'($urandom_range(40000)) - 20000;
    for (int i = 0; i < len; i++) begin
      add_pose(int'(i == 0 || $urandom_range(40) == 0), int'($urandom_range(15) != 0),
               fwd, lat, head);
      fwd  -= $urandom_range(3000);
      lat  = lat / 2 + int'($urandom_range(200)) - 100;
      head = head / 2 + int'($urandom_range(2000)) - 1000;
    end
  endfunction

  function automatic void add_noise();
    case ($urandom_range(2))
      0: add_pose($urandom, $urandom, $urandom, $urandom, $urandom);
      1: add_pose($urandom, $urandom, $urandom_range(70000), int'($urandom_range(2000)) - 1000,
                  $urandom);
      default: add_pose($urandom, $urandom, $urandom, int'($urandom_range(1400)) - 700,
                        int'($urandom_range(411774)) - 205887);
    endcase
  endfunction

  function automatic void add_random(int count);
    while (stim_q.size() < count) begin
      if ($urandom_range(4) != 0) add_run();
      else add_noise();
    end
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(1 << 20));
    endcase
  endfunction

  function automatic void pick_config(bit wide);
    for (int i = 0; i < NUM_REGS; i++) cfg_set[i] = pick_gain();
    if (!wide) begin
      cfg_set[REG_TURN_LIMIT] = GAIN_W'($urandom_range(1 << 20));
      cfg_set[REG_STOP_DIST]  = GAIN_W'($urandom_range(8000));
    end
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    board.write_reg(idx, val);
  endtask

  task automatic apply_config();
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), cfg_set[i]);
    // unmapped index, must be dropped
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)), GAIN_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pose(input pose_t p);
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, p.head, p.lat, p.fwd};
    s_tuser  <= {p.ok, p.first};
    do @(posedge clk); while (!s_axis_tready_o);
    board.note_pose(p);
  endtask

  task automatic drive_poses();
    int burst, gap;
    burst = 0;
    while (stim_q.size() > 0) begin
      if (burst == 0) burst = $urandom_range(1, 24);
      send_pose(stim_q.pop_front());
      burst--;
      if (burst == 0) begin
        gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (board.pending_cmds.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  initial begin : drain
    int seen, hold_left, mode_left, mode;
    bit held;
    seen      = 0;
    hold_left = 0;
    mode_left = 0;
    mode      = 0;
    held      = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid_o && m_tready) begin
        board.check_cmd(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o[0]);
        seen++;
      end
      // one long hold-off so the pipeline backs up into the input
      if (!held && seen >= 150) begin
        held      = 1'b1;
        hold_left = 120;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(3);
        mode_left = $urandom_range(32, 128);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= 1'($urandom_range(1));
          2: m_tready <= ($urandom_range(3) == 0);
          default: m_tready <= ~m_tready;
        endcase
      end
    end
  end

  initial begin
    #10_000_000;
    $display("docking_steer_pid verification failed");
    $finish;
  end

  initial begin
    int lat;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset gains
    add_pose(1, 1, 40000, 0, 0);
    add_pose(0, 1, 20000, 300, 1000);
    add_pose(0, 1, 5000, -654, -205887);
    add_pose(0, 1, 32767, 654, 205887);
    add_pose(0, 1, 32767, 655, 0);
    add_pose(0, 1, 32768, -100, 0);
    add_pose(0, 1, 6553, 10, -5);
    add_pose(0, 1, 6554, -10, 5);
    add_pose(0, 1, 197, 0, 0);
    add_pose(0, 1, 196, 0, 0);
    add_pose(0, 1, 32'sh80000000, 32'sh7fffffff, -262144);
    add_pose(0, 1, 32'sh7fffffff, 32'sh80000000, 262143);
    add_pose(0, 0, 12345, 5, 5);
    add_pose(1, 0, 12345, 5, 5);
    add_pose(0, 1, 12000, 5, 5);
    add_pose(0, 1, 100000, 100000, 0);
    add_pose(0, 1, 100000, -100000, 0);
    add_pose(1, 1, 0, 0, 0);
    add_pose(0, 1, -1, -1, -1);
    add_pose(0, 0, -1, -1, -1);
    add_pose(1, 1, 30000, 500, 100000);
    drive_poses();

    add_random(250);
    drive_poses();
    wait_idle();

    for (int i = 0; i < NUM_REGS; i++) cfg_set[i] = '0;
    apply_config();
    add_random(100);
    drive_poses();
    wait_idle();

    for (int i = 0; i < NUM_REGS; i++) cfg_set[i] = '1;
    apply_config();
    add_random(100);
    drive_poses();
    wait_idle();

    for (int k = 0; k < 3; k++) begin
      pick_config(k == 2);
      apply_config();
      add_random(180);
      drive_poses();
      wait_idle();
    end

    // heading sum built up with full-scale heading, one way then the other
    cfg_set[REG_GAIN_P_LAT]  = 24'd65536;
    cfg_set[REG_GAIN_D_LAT]  = 24'd32768;
    cfg_set[REG_GAIN_I_LAT]  = 24'd5;
    cfg_set[REG_GAIN_P_HEAD] = 24'd65536;
    cfg_set[REG_GAIN_D_HEAD] = 24'd12345;
    cfg_set[REG_GAIN_I_HEAD] = 24'd1;
    cfg_set[REG_TURN_LIMIT]  = '1;
    cfg_set[REG_STOP_DIST]   = '0;
    apply_config();
    for (int i = 0; i < 40; i++) begin
      lat = int'($urandom_range(1308)) - 654;
      add_pose(int'(i == 0), 1, $urandom_range(1000, 32767), lat, -262144);
    end
    for (int i = 0; i < 80; i++) begin
      lat = int'($urandom_range(1308)) - 654;
      add_pose(0, 1, $urandom_range(1000, 32767), lat, 262143);
    end
    drive_poses();

    while (board.pending_cmds.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending_cmds.size() == 0) begin
      $display("docking_steer_pid verification clean");
    end else begin
      $display("docking_steer_pid verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/dstp_pkg.sv
hw/rtl/dstp_cfg.sv
hw/rtl/dstp_err.sv
hw/rtl/dstp_mac.sv
hw/rtl/dstp_out.sv
hw/rtl/docking_steer_pid.sv
test/tb_docking_steer_pid.sv
